[sv/sart_pkg.sv]
`timescale 1ns / 1ps

package sart_pkg;

    localparam int TAG_W      = 32;
    localparam int SET_IDX_W  = 2;
    localparam int LINE_IDX_W = 3;

    localparam int DEF_SETS = 4;
    localparam int DEF_WAYS = 2;

    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0]     block_number;
        logic [SET_IDX_W-1:0] set_index;
    } sart_in_t;

    typedef struct packed {
        logic                  hit;
        logic [LINE_IDX_W-1:0] line_index;
    } sart_out_t;

endpackage

[sv/sart_lookup.sv]
`timescale 1ns / 1ps

module sart_lookup
    import sart_pkg::*;
#(
    parameter int WAYS   = DEF_WAYS,
    parameter int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1,
    parameter int FILL_W = $clog2(WAYS + 1)
)
(
    input  logic [TAG_W-1:0]  tag,
    input  logic              mode,
    input  logic [TAG_W-1:0]  row_tags [WAYS],
    input  logic [WAY_W-1:0]  row_age [WAYS],
    input  logic [FILL_W-1:0] fill,
    output logic              hit,
    output logic [WAY_W-1:0]  way,
    output logic              tag_we,
    output logic              fill_we,
    output logic [FILL_W-1:0] fill_next,
    output logic              age_we,
    output logic [WAY_W-1:0]  age_next [WAYS]
);

    logic              full;
    logic [WAYS-1:0]   way_match;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  hit_pos;
    logic              do_promote;
    logic [WAY_W-1:0]  promote_pos;
    logic [WAY_W-1:0]  promote_way;

    assign full = (fill == FILL_W'(WAYS));

    // only ways below the fill count hold live tags; tags are never duplicated
    always_comb
    begin
        hit_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            way_match[w] = (FILL_W'(w) < fill) && (row_tags[w] == tag);
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (way_match[w])
            begin
                hit_way = WAY_W'(w);
            end
        end
    end

    assign hit = |way_match;

    always_comb
    begin
        hit_pos = '0;
        for (int p = WAYS - 1; p >= 0; p--)
        begin
            if ((FILL_W'(p) < fill) && (row_age[p] == hit_way))
            begin
                hit_pos = WAY_W'(p);
            end
        end
    end

    assign do_promote  = hit ? (mode == MODE_LRU) : full;
    assign promote_pos = hit ? hit_pos : '0;
    assign promote_way = hit ? hit_way : row_age[0];

    always_comb
    begin
        if (hit)
        begin
            way = hit_way;
        end
        else if (full)
        begin
            way = row_age[0];
        end
        else
        begin
            way = WAY_W'(fill);
        end
    end

    assign tag_we    = !hit;
    assign fill_we   = !hit && !full;
    assign fill_next = fill + FILL_W'(1);
    assign age_we    = do_promote || fill_we;

    always_comb
    begin
        for (int k = 0; k < WAYS; k++)
        begin
            age_next[k] = row_age[k];
            if (do_promote)
            begin
                if (FILL_W'(k) == fill - FILL_W'(1))
                begin
                    age_next[k] = promote_way;
                end
                else if ((WAY_W'(k) >= promote_pos) && (FILL_W'(k + 1) < fill))
                begin
                    age_next[k] = row_age[(k + 1) % WAYS];
                end
            end
            else if (FILL_W'(k) == fill)
            begin
                age_next[k] = WAY_W'(fill);
            end
        end
    end

endmodule

[sv/set_assoc_replacement_tracker_unit.sv]
`timescale 1ns / 1ps

// Tag and replacement tracker for a set-associative cache.
// Input channel (in_valid / in_ready / in_data): one access per transfer,
// carrying the block number used as tag and the set index (wrapped to SETS).
// Output channel (out_valid / out_ready / out_data): one result per access,
// the hit flag and the line index, set * WAYS + way.
// cfg_we / cfg_wdata write the replacement mode (0 FIFO, 1 LRU); write only
// while no access is in flight.
// Each access is held in the input register, then its result in the output
// register until it transfers. One access is taken every cycle while the
// receiver does not stall: the access is registered, then the tag compare
// across all ways of the set, the age order update and the result register
// are done in one pass, so the next access already sees the updated set.
// When the receiver stalls, the result holds in the output register and one
// more access waits in the input register; in_ready then drops.
// Reset clears the fill counts, the mode (FIFO) and both valid flags; tags
// and age order need no clearing since only filled ways are read.
module set_assoc_replacement_tracker_unit
    import sart_pkg::*;
#(
    parameter int SETS = DEF_SETS,
    parameter int WAYS = DEF_WAYS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sart_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output sart_out_t out_data,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W = $clog2(WAYS + 1);

    logic                 mode_reg;
    logic                 s1_valid_reg;
    logic [TAG_W-1:0]     s1_tag_reg;
    logic [SET_W-1:0]     s1_set_reg;
    logic                 out_valid_reg;
    sart_out_t            out_data_reg;
    sart_out_t            out_data_next;

    logic [TAG_W-1:0]     tag_reg  [SETS][WAYS];
    logic [WAY_W-1:0]     age_reg  [SETS][WAYS];
    logic [FILL_W-1:0]    fill_reg [SETS];

    logic                 advance;
    logic [SET_IDX_W-1:0] set_red;

    logic                 hit;
    logic [WAY_W-1:0]     way;
    logic                 tag_we;
    logic                 fill_we;
    logic [FILL_W-1:0]    fill_next;
    logic                 age_we;
    logic [WAY_W-1:0]     age_next [WAYS];
    logic [31:0]          line_calc;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // set index wraps modulo SETS
    always_comb
    begin
        set_red = in_data.set_index;
        for (int i = 0; i < 3; i++)
        begin
            if ((SETS < 4) && (set_red >= SET_IDX_W'(SETS)))
            begin
                set_red = set_red - SET_IDX_W'(SETS);
            end
        end
    end

    sart_lookup #(
        .WAYS   (WAYS),
        .WAY_W  (WAY_W),
        .FILL_W (FILL_W)
    ) u_lookup (
        .tag       (s1_tag_reg),
        .mode      (mode_reg),
        .row_tags  (tag_reg[s1_set_reg]),
        .row_age   (age_reg[s1_set_reg]),
        .fill      (fill_reg[s1_set_reg]),
        .hit       (hit),
        .way       (way),
        .tag_we    (tag_we),
        .fill_we   (fill_we),
        .fill_next (fill_next),
        .age_we    (age_we),
        .age_next  (age_next)
    );

    assign line_calc = 32'(s1_set_reg) * 32'(WAYS) + 32'(way);

    always_comb
    begin
        out_data_next.hit        = hit;
        out_data_next.line_index = line_calc[LINE_IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_FIFO;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < SETS; s++)
            begin
                fill_reg[s] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance && fill_we)
            begin
                fill_reg[s1_set_reg] <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_tag_reg <= in_data.block_number;
            s1_set_reg <= SET_W'(set_red);
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
            if (tag_we)
            begin
                tag_reg[s1_set_reg][way] <= s1_tag_reg;
            end
            if (age_we)
            begin
                age_reg[s1_set_reg] <= age_next;
            end
        end
    end

endmodule
